>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PFD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PFD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pfd_pkg.sv
`timescale 1ns / 1ps

package pfd_pkg;

    localparam int LETTER_W = 5;
    localparam int ADDR_W   = 5;
    localparam int SIDE     = 5;
    localparam int CELLS    = SIDE * SIDE;
    localparam int LETTERS  = 26;
    localparam int ROW_W    = 3;

    localparam logic [LETTER_W-1:0] LETTER_I    = LETTER_W'(8);
    localparam logic [LETTER_W-1:0] LETTER_J    = LETTER_W'(9);
    localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(LETTERS - 1);

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_FINISH = 2'd1,
        FUNC_DECODE = 2'd2,
        FUNC_RSVD   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_SAME      = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    typedef struct packed {
        logic                en;
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [LETTER_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic [LETTER_W-1:0] plain_a;
        logic [LETTER_W-1:0] plain_b;
        status_t             status;
    } result_t;

    typedef struct packed {
        logic                busy;
        logic                square_ready;
        logic [ADDR_W-1:0]   fill_count;
    } ctrl_status_t;

    function automatic logic [LETTER_W-1:0] fold_letter(input logic [LETTER_W-1:0] c);
        return (c == LETTER_J) ? LETTER_I : c;
    endfunction

    function automatic logic [ROW_W-1:0] place_row(input logic [ADDR_W-1:0] p);
        logic [ROW_W-1:0] r;
        r = '0;
        if (p >= ADDR_W'(4 * SIDE))
        begin
            r = ROW_W'(4);
        end
        else if (p >= ADDR_W'(3 * SIDE))
        begin
            r = ROW_W'(3);
        end
        else if (p >= ADDR_W'(2 * SIDE))
        begin
            r = ROW_W'(2);
        end
        else if (p >= ADDR_W'(SIDE))
        begin
            r = ROW_W'(1);
        end
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] place_col(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] diff;
        base = ADDR_W'(place_row(p)) * ADDR_W'(SIDE);
        diff = p - base;
        return diff[ROW_W-1:0];
    endfunction

    function automatic logic [ROW_W-1:0] step_back(input logic [ROW_W-1:0] v);
        return (v == '0) ? ROW_W'(SIDE - 1) : v - ROW_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_index(
        input logic [ROW_W-1:0] r,
        input logic [ROW_W-1:0] c
    );
        return ADDR_W'(r) * ADDR_W'(SIDE) + ADDR_W'(c);
    endfunction

endpackage

>>> rtl/pfd_if.sv
`timescale 1ns / 1ps

interface pfd_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   func;
    logic [pfd_pkg::LETTER_W-1:0] letter_a;
    logic [pfd_pkg::LETTER_W-1:0] letter_b;

    modport source (output valid, output func, output letter_a, output letter_b, input ready);
    modport sink   (input valid, input func, input letter_a, input letter_b, output ready);
endinterface

interface pfd_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [pfd_pkg::LETTER_W-1:0] plain_a;
    logic [pfd_pkg::LETTER_W-1:0] plain_b;
    logic [1:0]                   status;

    modport source (output valid, output plain_a, output plain_b, output status, input ready);
    modport sink   (input valid, input plain_a, input plain_b, input status, output ready);
endinterface

>>> rtl/pfd_ram.sv
`timescale 1ns / 1ps

module pfd_ram #(
    parameter int DEPTH = pfd_pkg::CELLS
) (
    input  logic                         clk,
    input  pfd_pkg::mem_req_t            req,
    output logic [pfd_pkg::LETTER_W-1:0] rdata
);

    logic [pfd_pkg::LETTER_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rdata <= mem[req.addr];
            end
        end
    end

endmodule

>>> rtl/pfd_ctrl.sv
`timescale 1ns / 1ps

module pfd_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic [1:0]                   req_func,
    input  logic [pfd_pkg::LETTER_W-1:0] req_letter_a,
    input  logic [pfd_pkg::LETTER_W-1:0] req_letter_b,
    output pfd_pkg::mem_req_t            place_req,
    input  logic [pfd_pkg::LETTER_W-1:0] place_rdata,
    output pfd_pkg::mem_req_t            cell_req,
    input  logic [pfd_pkg::LETTER_W-1:0] cell_rdata,
    input  logic                         out_free,
    output logic                         res_valid,
    output pfd_pkg::result_t             res,
    output pfd_pkg::ctrl_status_t        stat
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_KEY   = 9'b000000010,
        S_FILL  = 9'b000000100,
        S_RDA   = 9'b000001000,
        S_RDB   = 9'b000010000,
        S_CELLA = 9'b000100000,
        S_CELLB = 9'b001000000,
        S_LAST  = 9'b010000000,
        S_RESP  = 9'b100000000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [pfd_pkg::LETTER_W-1:0]    fa_reg;
    logic [pfd_pkg::LETTER_W-1:0]    fb_reg;
    logic [pfd_pkg::LETTER_W-1:0]    walk_reg;
    logic [pfd_pkg::LETTERS-1:0]     seen_reg;
    logic [pfd_pkg::ADDR_W-1:0]      fill_reg;
    logic                            ready_reg;
    logic [pfd_pkg::ADDR_W-1:0]      pa_reg;
    logic [pfd_pkg::ADDR_W-1:0]      ob_reg;
    logic [pfd_pkg::LETTER_W-1:0]    plain_a_reg;
    logic [pfd_pkg::LETTER_W-1:0]    plain_b_reg;
    pfd_pkg::status_t                status_reg;

    logic                            accept;
    pfd_pkg::func_t                  func_in;
    logic [pfd_pkg::LETTER_W-1:0]    fold_a;
    logic [pfd_pkg::LETTER_W-1:0]    fold_b;
    logic                            a_bad;
    logic                            b_bad;
    logic [pfd_pkg::LETTER_W-1:0]    ins_letter;
    logic                            ins_ok;
    logic [pfd_pkg::ROW_W-1:0]       ra;
    logic [pfd_pkg::ROW_W-1:0]       ca;
    logic [pfd_pkg::ROW_W-1:0]       rb;
    logic [pfd_pkg::ROW_W-1:0]       cb;
    logic [pfd_pkg::ADDR_W-1:0]      oa;
    logic [pfd_pkg::ADDR_W-1:0]      ob;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign func_in   = pfd_pkg::func_t'(req_func);
    assign fold_a    = pfd_pkg::fold_letter(req_letter_a);
    assign fold_b    = pfd_pkg::fold_letter(req_letter_b);
    assign a_bad     = (req_letter_a > pfd_pkg::LAST_LETTER);
    assign b_bad     = (req_letter_b > pfd_pkg::LAST_LETTER);

    assign ins_letter = (state_reg == S_KEY) ? fa_reg : walk_reg;
    assign ins_ok     = !seen_reg[ins_letter]
                     && (fill_reg < pfd_pkg::ADDR_W'(pfd_pkg::CELLS))
                     && !((state_reg == S_FILL) && (walk_reg == pfd_pkg::LETTER_J));

    // pa from the earlier read, pb arriving now
    always_comb
    begin
        ra = pfd_pkg::place_row(pa_reg);
        ca = pfd_pkg::place_col(pa_reg);
        rb = pfd_pkg::place_row(place_rdata);
        cb = pfd_pkg::place_col(place_rdata);
        if (ra == rb)
        begin
            oa = pfd_pkg::cell_index(ra, pfd_pkg::step_back(ca));
            ob = pfd_pkg::cell_index(rb, pfd_pkg::step_back(cb));
        end
        else if (ca == cb)
        begin
            oa = pfd_pkg::cell_index(pfd_pkg::step_back(ra), ca);
            ob = pfd_pkg::cell_index(pfd_pkg::step_back(rb), cb);
        end
        else
        begin
            oa = pfd_pkg::cell_index(ra, cb);
            ob = pfd_pkg::cell_index(rb, ca);
        end
    end

    always_comb
    begin
        place_req = '0;
        cell_req  = '0;
        unique case (state_reg)
            S_KEY, S_FILL:
            begin
                place_req.en    = ins_ok;
                place_req.we    = 1'b1;
                place_req.addr  = ins_letter;
                place_req.wdata = fill_reg;
                cell_req.en     = ins_ok;
                cell_req.we     = 1'b1;
                cell_req.addr   = fill_reg;
                cell_req.wdata  = ins_letter;
            end
            S_RDA:
            begin
                place_req.en   = 1'b1;
                place_req.addr = fa_reg;
            end
            S_RDB:
            begin
                place_req.en   = 1'b1;
                place_req.addr = fb_reg;
            end
            S_CELLA:
            begin
                cell_req.en   = 1'b1;
                cell_req.addr = oa;
            end
            S_CELLB:
            begin
                cell_req.en   = 1'b1;
                cell_req.addr = ob_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (func_in)
                        pfd_pkg::FUNC_ADD:
                        begin
                            state_next = (a_bad || ready_reg) ? S_RESP : S_KEY;
                        end
                        pfd_pkg::FUNC_FINISH:
                        begin
                            state_next = ready_reg ? S_RESP : S_FILL;
                        end
                        pfd_pkg::FUNC_DECODE:
                        begin
                            state_next = (a_bad || b_bad || !ready_reg || fold_a == fold_b)
                                       ? S_RESP : S_RDA;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_KEY:   state_next = S_RESP;
            S_FILL:
            begin
                if (walk_reg == pfd_pkg::LAST_LETTER)
                begin
                    state_next = S_RESP;
                end
            end
            S_RDA:   state_next = S_RDB;
            S_RDB:   state_next = S_CELLA;
            S_CELLA: state_next = S_CELLB;
            S_CELLB: state_next = S_LAST;
            S_LAST:  state_next = S_RESP;
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seen_reg  <= '0;
            fill_reg  <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_KEY || state_reg == S_FILL) && ins_ok)
            begin
                seen_reg[ins_letter] <= 1'b1;
                fill_reg             <= fill_reg + pfd_pkg::ADDR_W'(1);
            end
            if (state_reg == S_FILL && walk_reg == pfd_pkg::LAST_LETTER)
            begin
                ready_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fa_reg      <= fold_a;
                    fb_reg      <= fold_b;
                    walk_reg    <= '0;
                    plain_a_reg <= '0;
                    plain_b_reg <= '0;
                    status_reg  <= pfd_pkg::ST_OK;
                    case (func_in)
                        pfd_pkg::FUNC_ADD:
                        begin
                            if (a_bad)
                            begin
                                status_reg <= pfd_pkg::ST_INVALID;
                            end
                            else if (ready_reg)
                            begin
                                status_reg <= pfd_pkg::ST_NOT_READY;
                            end
                        end
                        pfd_pkg::FUNC_FINISH:
                        begin
                            if (ready_reg)
                            begin
                                status_reg <= pfd_pkg::ST_NOT_READY;
                            end
                        end
                        pfd_pkg::FUNC_DECODE:
                        begin
                            if (a_bad || b_bad)
                            begin
                                status_reg <= pfd_pkg::ST_INVALID;
                            end
                            else if (!ready_reg)
                            begin
                                status_reg <= pfd_pkg::ST_NOT_READY;
                            end
                            else if (fold_a == fold_b)
                            begin
                                status_reg <= pfd_pkg::ST_SAME;
                            end
                        end
                        default:
                        begin
                            status_reg <= pfd_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            S_FILL:  walk_reg    <= walk_reg + pfd_pkg::LETTER_W'(1);
            S_RDB:   pa_reg      <= place_rdata;
            S_CELLA: ob_reg      <= ob;
            S_CELLB: plain_a_reg <= cell_rdata;
            S_LAST:  plain_b_reg <= cell_rdata;
            default:
            begin
            end
        endcase
    end

    assign res_valid         = (state_reg == S_RESP) && out_free;
    assign res.plain_a       = plain_a_reg;
    assign res.plain_b       = plain_b_reg;
    assign res.status        = status_reg;
    assign stat.busy         = (state_reg != S_IDLE);
    assign stat.square_ready = ready_reg;
    assign stat.fill_count   = fill_reg;

endmodule

>>> rtl/playfair_digraph_decoder_core.sv
// A key request steps through S_KEY, a finish through the alphabet walk in S_FILL,
// a decode through S_RDA, S_RDB, S_CELLA, S_CELLB and S_LAST; a request rejected
// with an error status goes straight to S_RESP. A rsp stall holds the result in
// S_RESP, and a new request is taken only once it has left; decode is bound by two
// place reads and two cell reads through single-port memories, finish by the walk.
// Reset (rst_n, async low) clears the control state; the memories are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module playfair_digraph_decoder_core (
    input  logic            clk,
    input  logic            rst_n,
    pfd_req_if.sink         req,
    pfd_rsp_if.source       rsp
);

    pfd_pkg::mem_req_t            place_req;
    pfd_pkg::mem_req_t            cell_req;
    logic [pfd_pkg::LETTER_W-1:0] place_rdata;
    logic [pfd_pkg::LETTER_W-1:0] cell_rdata;
    logic                         out_free;
    logic                         res_valid;
    pfd_pkg::result_t             res;
    pfd_pkg::ctrl_status_t        stat;
    logic                         square_full;

    logic                         rsp_valid_reg;
    pfd_pkg::result_t             rsp_data_reg;

    pfd_ram #(
        .DEPTH (pfd_pkg::LETTERS)
    ) u_place_ram (
        .clk   (clk),
        .req   (place_req),
        .rdata (place_rdata)
    );

    pfd_ram #(
        .DEPTH (pfd_pkg::CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .req   (cell_req),
        .rdata (cell_rdata)
    );

    pfd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req.valid),
        .req_ready    (req.ready),
        .req_func     (req.func),
        .req_letter_a (req.letter_a),
        .req_letter_b (req.letter_b),
        .place_req    (place_req),
        .place_rdata  (place_rdata),
        .cell_req     (cell_req),
        .cell_rdata   (cell_rdata),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res          (res),
        .stat         (stat)
    );

    assign out_free = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.plain_a = rsp_data_reg.plain_a;
    assign rsp.plain_b = rsp_data_reg.plain_b;
    assign rsp.status  = rsp_data_reg.status;

    assign square_full = (stat.fill_count == pfd_pkg::ADDR_W'(pfd_pkg::CELLS));

    `PFD_ASSERT_IMP(a_ready_full, stat.square_ready, square_full, "ready with cells unfilled")
    `PFD_ASSERT_NXT(a_one_in_flight, req.valid && req.ready, !req.ready, "second request taken")
    `PFD_ASSERT_IMP(a_no_overwrite, res_valid, out_free, "pending response overwritten")
    `PFD_ASSERT_IMP(a_idle_no_result, !stat.busy, !res_valid, "result issued while idle")

endmodule

>>> verif/tb_playfair_digraph_decoder_core.sv
`timescale 1ns / 1ps

module tb_playfair_digraph_decoder_core;
    import pfd_pkg::*;

    localparam logic [LETTER_W-1:0] FIRST_BAD_CODE = LETTER_W'(LETTERS);
    localparam logic [LETTER_W-1:0] MAX_CODE       = '1;
    localparam int                  DRAIN_CYCLES   = 40;

    logic clk = 1'b0;
    logic rst_n;

    pfd_req_if req_if ();
    pfd_rsp_if rsp_if ();

    playfair_digraph_decoder_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow of the square
    logic [LETTER_W-1:0] cell_letter [CELLS];
    logic [ADDR_W-1:0]   letter_cell [LETTERS];
    logic [LETTERS-1:0]  letters_present = '0;
    int                  cells_filled    = 0;
    bit                  square_done     = 1'b0;

    result_t pending_plaintext [$];

    int send_idle_pct  = 0;
    int rsp_stall_pct  = 0;
    int fail_count     = 0;
    int request_count  = 0;
    int result_count   = 0;
    int row_decodes    = 0;
    int column_decodes = 0;
    int rect_decodes   = 0;
    int error_results  = 0;

    function automatic void enter_letter(input logic [LETTER_W-1:0] c);
        if (cells_filled >= CELLS || letters_present[c])
        begin
            return;
        end
        cell_letter[cells_filled] = c;
        letter_cell[c]            = ADDR_W'(cells_filled);
        letters_present[c]        = 1'b1;
        cells_filled++;
    endfunction

    function automatic result_t playfair_response(
        input func_t               f,
        input logic [LETTER_W-1:0] a,
        input logic [LETTER_W-1:0] b
    );
        result_t             res;
        logic [LETTER_W-1:0] fa;
        logic [LETTER_W-1:0] fb;
        int                  ra;
        int                  ca;
        int                  rb;
        int                  cb;
        int                  oa;
        int                  ob;
        res        = '0;
        res.status = ST_OK;
        fa = (a == LETTER_J) ? LETTER_I : a;
        fb = (b == LETTER_J) ? LETTER_I : b;
        case (f)
            FUNC_ADD:
            begin
                if (a > LAST_LETTER)
                begin
                    res.status = ST_INVALID;
                end
                else if (square_done)
                begin
                    res.status = ST_NOT_READY;
                end
                else
                begin
                    enter_letter(fa);
                end
            end
            FUNC_FINISH:
            begin
                if (square_done)
                begin
                    res.status = ST_NOT_READY;
                end
                else
                begin
                    for (int c = 0; c < LETTERS; c++)
                    begin
                        if (LETTER_W'(c) != LETTER_J)
                        begin
                            enter_letter(LETTER_W'(c));
                        end
                    end
                    square_done = 1'b1;
                end
            end
            FUNC_DECODE:
            begin
                if (a > LAST_LETTER || b > LAST_LETTER)
                begin
                    res.status = ST_INVALID;
                end
                else if (!square_done)
                begin
                    res.status = ST_NOT_READY;
                end
                else if (fa == fb)
                begin
                    res.status = ST_SAME;
                end
                else
                begin
                    ra = int'(letter_cell[fa]) / SIDE;
                    ca = int'(letter_cell[fa]) % SIDE;
                    rb = int'(letter_cell[fb]) / SIDE;
                    cb = int'(letter_cell[fb]) % SIDE;
                    if (ra == rb)
                    begin
                        oa = ra * SIDE + (ca + SIDE - 1) % SIDE;
                        ob = rb * SIDE + (cb + SIDE - 1) % SIDE;
                        row_decodes++;
                    end
                    else if (ca == cb)
                    begin
                        oa = ((ra + SIDE - 1) % SIDE) * SIDE + ca;
                        ob = ((rb + SIDE - 1) % SIDE) * SIDE + cb;
                        column_decodes++;
                    end
                    else
                    begin
                        oa = ra * SIDE + cb;
                        ob = rb * SIDE + ca;
                        rect_decodes++;
                    end
                    res.plain_a = cell_letter[oa];
                    res.plain_b = cell_letter[ob];
                end
            end
            default:
            begin
                res.status = ST_INVALID;
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_request(
        input func_t               f,
        input logic [LETTER_W-1:0] a,
        input logic [LETTER_W-1:0] b
    );
        result_t expected;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid    = 1'b1;
        req_if.func     = f;
        req_if.letter_a = a;
        req_if.letter_b = b;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
        expected          = playfair_response(f, a, b);
        pending_plaintext = {pending_plaintext, expected};
        request_count++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_if.valid = 1'b0;
        while (pending_plaintext.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    always @(negedge clk)
    begin
        rsp_if.ready = ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            result_count++;
            if (pending_plaintext.size() == 0)
            begin
                report_mismatch("unexpected response, status", rsp_if.status, -1);
            end
            else
            begin
                want = pending_plaintext.pop_front();
                if (want.status != ST_OK)
                begin
                    error_results++;
                end
                if (rsp_if.status !== want.status)
                begin
                    report_mismatch("status", rsp_if.status, want.status);
                end
                if (rsp_if.plain_a !== want.plain_a)
                begin
                    report_mismatch("plain_a", rsp_if.plain_a, want.plain_a);
                end
                if (rsp_if.plain_b !== want.plain_b)
                begin
                    report_mismatch("plain_b", rsp_if.plain_b, want.plain_b);
                end
            end
        end
    end

    task automatic test_early_requests();
        send_request(FUNC_DECODE, 5'd0, 5'd1);
        send_request(FUNC_DECODE, LAST_LETTER, FIRST_BAD_CODE);
        send_request(FUNC_RSVD, MAX_CODE, MAX_CODE);
        send_request(FUNC_ADD, MAX_CODE, 5'd0);
    endtask

    task automatic test_key_entry();
        send_request(FUNC_ADD, LETTER_J, 5'd0);
        send_request(FUNC_ADD, LETTER_I, MAX_CODE);
        send_request(FUNC_ADD, LAST_LETTER, 5'd0);
        send_request(FUNC_ADD, 5'd0, 5'd0);
        send_request(FUNC_ADD, FIRST_BAD_CODE, LETTER_W'($urandom_range(31)));
        repeat (4)
        begin
            send_request(FUNC_ADD, LETTER_W'($urandom_range(25)),
                         LETTER_W'($urandom_range(31)));
        end
    endtask

    task automatic test_finish_square();
        send_request(FUNC_FINISH, MAX_CODE, MAX_CODE);
        wait_drained();
        send_request(FUNC_FINISH, 5'd0, 5'd0);
        send_request(FUNC_ADD, 5'd1, 5'd0);
    endtask

    task automatic test_decode_directed();
        // key starts with J, so cell 0 holds I
        send_request(FUNC_DECODE, LETTER_J, cell_letter[0]);
        send_request(FUNC_DECODE, cell_letter[0], cell_letter[4]);
        send_request(FUNC_DECODE, cell_letter[0], cell_letter[20]);
        send_request(FUNC_DECODE, cell_letter[0], cell_letter[24]);
        send_request(FUNC_DECODE, cell_letter[12], cell_letter[13]);
        send_request(FUNC_DECODE, cell_letter[7], cell_letter[17]);
        send_request(FUNC_DECODE, 5'd0, LAST_LETTER);
        send_request(FUNC_DECODE, FIRST_BAD_CODE, 5'd0);
        send_request(FUNC_DECODE, 5'd0, MAX_CODE);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
        int                  pick;
        logic [LETTER_W-1:0] x;
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        repeat (count)
        begin
            pick = $urandom_range(99);
            x    = LETTER_W'($urandom_range(25));
            if (pick < 80)
            begin
                send_request(FUNC_DECODE, x, LETTER_W'($urandom_range(25)));
            end
            else if (pick < 85)
            begin
                send_request(FUNC_DECODE, LETTER_W'($urandom_range(31)),
                             LETTER_W'($urandom_range(31)));
            end
            else if (pick < 89)
            begin
                send_request(FUNC_DECODE, x, ($urandom_range(1) != 0) ? x :
                             ((x == LETTER_I) ? LETTER_J : LETTER_I));
            end
            else if (pick < 93)
            begin
                send_request(FUNC_RSVD, LETTER_W'($urandom_range(31)),
                             LETTER_W'($urandom_range(31)));
            end
            else if (pick < 97)
            begin
                send_request(FUNC_ADD, LETTER_W'($urandom_range(31)),
                             LETTER_W'($urandom_range(31)));
            end
            else
            begin
                send_request(FUNC_FINISH, LETTER_W'($urandom_range(31)),
                             LETTER_W'($urandom_range(31)));
            end
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        req_if.valid    = 1'b0;
        req_if.func     = FUNC_ADD;
        req_if.letter_a = '0;
        req_if.letter_b = '0;
        rsp_if.ready    = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_early_requests();
        test_key_entry();
        test_finish_square();
        test_decode_directed();
        wait_drained();
        test_random_traffic(300, 10, 47);
        test_random_traffic(300, 47, 10);
        test_random_traffic(300, 0, 0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_plaintext.size() != 0)
        begin
            report_mismatch("responses outstanding", 0, pending_plaintext.size());
        end
        $display("Sent %0d requests, checked %0d responses, %0d of them error statuses.",
                 request_count, result_count, error_results);
        $display("Decodes by case: same row %0d, same column %0d, rectangle %0d.",
                 row_decodes, column_decodes, rect_decodes);
        if (fail_count == 0)
        begin
            $display("PASS playfair_digraph_decoder_core");
        end
        else
        begin
            $display("FAIL playfair_digraph_decoder_core");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d responses outstanding", pending_plaintext.size());
        $display("FAIL playfair_digraph_decoder_core");
        $finish;
    end

endmodule
